[hw/rtl/free_list_object_allocator_defines.svh]
// Assertion macros shared by the free list object allocator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FREE_LIST_OBJECT_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_OBJECT_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FLA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Check that cons holds in the cycle after ante.
`define FLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[hw/rtl/fla_pkg.sv]
// Package for the free list object allocator: pool size, link encoding,
// action codes, transfer structs and the link reset pattern. No dependencies.
`timescale 1ns / 1ps

package fla_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned LINK_W = SLOT_W + 1;

  // Link value that points nowhere.
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              status;
  } res_t;

  // One access per cycle on a link memory: read or write.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } link_port_t;

  // Next link of a slot after reset: the following slot, the last none.
  function automatic logic [LINK_W-1:0] link_reset(input logic [SLOT_W-1:0] a);
    logic [LINK_W-1:0] r;
    if (a == SLOT_W'(SLOTS - 1)) begin
      r = LINK_NONE;
    end else begin
      r = LINK_W'(a) + LINK_W'(1);
    end
    return r;
  endfunction

endpackage

[hw/rtl/free_list_object_allocator.sv]
// Top level of the free list object allocator: command sequencer, list heads,
// allocated bits and value store. Depends on fla_pkg, fla_links and the defines header.
`timescale 1ns / 1ps
`include "free_list_object_allocator_defines.svh"

// Usage:
//   Command channel: drive req_i and raise start; the command transfers at a
//   rising edge where start is high and busy is low. busy stays high from the
//   transfer until the result is shown.
//   Result channel: done_o pulses for exactly one cycle with res_o. The
//   receiver cannot stall, so each result is taken in the cycle it appears.
//   Every command gives exactly one result.
//   busy drops in the same cycle that done_o goes high. An allocate from a
//   non-empty pool steps through link and back states, and a free of an
//   allocated slot through link and push states; an allocate on a full pool, an
//   ignored free, a write and an unused action answer straight from decode.
//   The sequence is set by the single port on each link memory: a free reads
//   the slot's next and prev links, patches the neighbors, then relinks the slot,
//   one memory step per cycle under the sequencer.
//   A new command may transfer in the cycle done_o is high, so a command is
//   taken only after the previous command has given its result.
//   Reset: free list holds every slot in order starting at slot zero, used
//   list is empty, no slot allocated. Link memories need no clearing pass:
//   unwritten next links read as their reset pattern through valid bits.
module free_list_object_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fla_pkg::req_t req_i,
  output logic          done_o,
  output fla_pkg::res_t res_o
);
  import fla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_LINK,
    S_ALLOC_BACK,
    S_FREE_LINK,
    S_FREE_PUSH
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [SLOT_W-1:0] cur_q, cur_d;          // slot being moved between lists
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [LINK_W-1:0] used_head_q, used_head_d;
  logic [SLOTS-1:0]  in_use_q, in_use_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  link_port_t        next_port, prev_port;
  logic [LINK_W-1:0] next_rdata, prev_rdata;
  logic              val_we;
  logic [31:0]       slot_value [SLOTS];
  logic              slot_in_pool;

  fla_links u_links (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .next_port_i  (next_port),
    .prev_port_i  (prev_port),
    .next_rdata_o (next_rdata),
    .prev_rdata_o (prev_rdata)
  );

  assign slot_in_pool = ({1'b0, req_q.slot} < LINK_NONE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cur_d       = cur_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    in_use_d    = in_use_q;
    done_d      = 1'b0;
    res_d       = res_q;
    next_port   = '0;
    prev_port   = '0;
    val_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d   = '0;
        state_d = S_IDLE;
        case (req_q.action)
          ACT_ALLOC: begin
            if (free_head_q == LINK_NONE) begin
              // Pool full: answer failure, change nothing.
              res_d.status = 1'b1;
              done_d       = 1'b1;
            end else begin
              cur_d           = free_head_q[SLOT_W-1:0];
              next_port.rd_en = 1'b1;
              next_port.addr  = free_head_q[SLOT_W-1:0];
              state_d         = S_ALLOC_LINK;
            end
          end
          ACT_FREE: begin
            if (slot_in_pool && in_use_q[req_q.slot]) begin
              cur_d           = req_q.slot;
              next_port.rd_en = 1'b1;
              next_port.addr  = req_q.slot;
              prev_port.rd_en = 1'b1;
              prev_port.addr  = req_q.slot;
              state_d         = S_FREE_LINK;
            end else begin
              // Drop frees of slots that are not allocated.
              done_d = 1'b1;
            end
          end
          ACT_WRITE: begin
            val_we = slot_in_pool;
            done_d = 1'b1;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end

      S_ALLOC_LINK: begin
        // Pop the free head, point the new slot at the old used head.
        free_head_d     = next_rdata;
        next_port.wr_en = 1'b1;
        next_port.addr  = cur_q;
        next_port.wdata = used_head_q;
        prev_port.wr_en = 1'b1;
        prev_port.addr  = cur_q;
        prev_port.wdata = LINK_NONE;
        state_d         = S_ALLOC_BACK;
      end

      S_ALLOC_BACK: begin
        if (used_head_q != LINK_NONE) begin
          prev_port.wr_en = 1'b1;
          prev_port.addr  = used_head_q[SLOT_W-1:0];
          prev_port.wdata = {1'b0, cur_q};
        end
        used_head_d         = {1'b0, cur_q};
        in_use_d[cur_q]     = 1'b1;
        res_d.granted_slot  = cur_q;
        done_d              = 1'b1;
        state_d             = S_IDLE;
      end

      S_FREE_LINK: begin
        // Bridge the neighbors around the slot being freed.
        if (next_rdata != LINK_NONE) begin
          prev_port.wr_en = 1'b1;
          prev_port.addr  = next_rdata[SLOT_W-1:0];
          prev_port.wdata = prev_rdata;
        end
        if (prev_rdata != LINK_NONE) begin
          next_port.wr_en = 1'b1;
          next_port.addr  = prev_rdata[SLOT_W-1:0];
          next_port.wdata = next_rdata;
        end else begin
          used_head_d = next_rdata;
        end
        state_d = S_FREE_PUSH;
      end

      S_FREE_PUSH: begin
        // Push the slot onto the free list.
        next_port.wr_en = 1'b1;
        next_port.addr  = cur_q;
        next_port.wdata = free_head_q;
        prev_port.wr_en = 1'b1;
        prev_port.addr  = cur_q;
        prev_port.wdata = LINK_NONE;
        free_head_d     = {1'b0, cur_q};
        in_use_d[cur_q] = 1'b0;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      cur_q       <= '0;
      free_head_q <= '0;
      used_head_q <= LINK_NONE;
      in_use_q    <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      cur_q       <= cur_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      in_use_q    <= in_use_d;
      done_q      <= done_d;
      res_q       <= res_d;
    end
  end

  // Slot values are kept but never read back by any command.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      slot_value[req_q.slot] <= req_q.value;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `FLA_ASSERT_SAME(a_done_not_busy, done_o, !busy)
  `FLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FLA_ASSERT_SAME(a_fail_when_full, done_o && res_o.status,
                   (free_head_q == LINK_NONE) && (res_o.granted_slot == '0))
  `FLA_ASSERT_SAME(a_used_head_alloc, used_head_q != LINK_NONE,
                   in_use_q[used_head_q[SLOT_W-1:0]])

endmodule

[hw/rtl/fla_links.sv]
// Link store of the allocator: next and prev link memories, one port each.
// Depends on fla_pkg.
`timescale 1ns / 1ps

module fla_links (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fla_pkg::link_port_t        next_port_i,
  input  fla_pkg::link_port_t        prev_port_i,
  output logic [fla_pkg::LINK_W-1:0] next_rdata_o,
  output logic [fla_pkg::LINK_W-1:0] prev_rdata_o
);
  import fla_pkg::*;

  logic [LINK_W-1:0] next_mem [SLOTS];
  logic [LINK_W-1:0] prev_mem [SLOTS];
  logic [SLOTS-1:0]  next_vld_q;
  logic [LINK_W-1:0] next_rd_q;
  logic [LINK_W-1:0] prev_rd_q;
  logic              next_hit_q;
  logic [SLOT_W-1:0] next_addr_q;

  always_ff @(posedge clk_i) begin
    if (next_port_i.wr_en) begin
      next_mem[next_port_i.addr] <= next_port_i.wdata;
    end
    if (next_port_i.rd_en) begin
      next_rd_q <= next_mem[next_port_i.addr];
    end
    if (prev_port_i.wr_en) begin
      prev_mem[prev_port_i.addr] <= prev_port_i.wdata;
    end
    if (prev_port_i.rd_en) begin
      prev_rd_q <= prev_mem[prev_port_i.addr];
    end
  end

  // Unwritten next entries read back as their reset pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q  <= '0;
      next_hit_q  <= 1'b0;
      next_addr_q <= '0;
    end else begin
      if (next_port_i.wr_en) begin
        next_vld_q[next_port_i.addr] <= 1'b1;
      end
      if (next_port_i.rd_en) begin
        next_hit_q  <= next_vld_q[next_port_i.addr];
        next_addr_q <= next_port_i.addr;
      end
    end
  end

  assign next_rdata_o = next_hit_q ? next_rd_q : link_reset(next_addr_q);
  assign prev_rdata_o = prev_rd_q;

endmodule
